@@ rtl/encoder_move_sequencer_top_assert.svh @@
// Assertion macros shared by the move sequencer RTL.
`ifndef ENCODER_MOVE_SEQUENCER_TOP_ASSERT_SVH
`define ENCODER_MOVE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EMSEQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EMSEQ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/emseq_pkg.sv @@
// Types, widths and reset values shared by the move sequencer modules.
package emseq_pkg;

  localparam int ENCODER_COUNTS_DEF = 8192;

  localparam int CMD_W        = 2;
  localparam int NOW_W        = 32;
  localparam int ANGLE_W      = 13;
  localparam int DIST_MM_W    = 21;
  localparam int DIST_TICKS_W = 40;
  localparam int POS_W        = 48;
  localparam int TICKS_MM_W   = 24;
  localparam int STEP_W       = 20;
  localparam int THR_W        = 16;
  localparam int TIMEOUT_W    = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int MODE_W       = 2;

  localparam logic [TICKS_MM_W-1:0] TICKS_MM_RST = TICKS_MM_W'(209715);
  localparam logic [STEP_W-1:0]     STEP_RST     = STEP_W'(104858);
  localparam logic [THR_W-1:0]      THR_RST      = THR_W'(300);
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(60000);

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_START  = 2'd1,
    CMD_ABORT  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_MM = 2'd0,
    CFG_STEP_PER_MS  = 2'd1,
    CFG_ARRIVE_THR   = 2'd2,
    CFG_TIMEOUT      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TICKS_MM_W-1:0] ticks_per_mm_q8;
    logic [STEP_W-1:0]     step_per_ms_q8;
    logic [THR_W-1:0]      arrive_threshold;
    logic [TIMEOUT_W-1:0]  timeout_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t                         command;
    logic [NOW_W-1:0]             now_ms;
    logic [ANGLE_W-1:0]           encoder_angle;
    logic signed [DIST_MM_W-1:0]  distance_mm_q8;
  } item_t;

  typedef struct packed {
    mode_t                        mode;
    logic                         dir_neg;
    logic [DIST_TICKS_W-1:0]      dist_ticks_q8;
    logic signed [POS_W-1:0]      target;
    logic signed [POS_W-1:0]      travel;
    logic [ANGLE_W-1:0]           prev_angle;
    logic [NOW_W-1:0]             start_time;
    logic [NOW_W-1:0]             prev_time;
  } seq_state_t;

endpackage

@@ rtl/emseq_step.sv @@
// Single-pass next-state logic of the move sequencer for one command word.
module emseq_step #(
  parameter int ENCODER_COUNTS = emseq_pkg::ENCODER_COUNTS_DEF
) (
  input  emseq_pkg::cfg_t       cfg,
  input  emseq_pkg::seq_state_t cur,
  input  emseq_pkg::item_t      item,
  output emseq_pkg::seq_state_t nxt
);

  localparam int AW      = emseq_pkg::ANGLE_W;
  localparam int ENC_LOG = $clog2(ENCODER_COUNTS);
  localparam int DW      = ((AW > ENC_LOG) ? AW : ENC_LOG) + 2;
  localparam int PW      = emseq_pkg::POS_W;
  localparam int SW      = PW + 1;
  localparam int MW      = emseq_pkg::DIST_MM_W;
  localparam int TW      = emseq_pkg::TICKS_MM_W;
  localparam int DPW     = MW + TW;
  localparam int RPW     = emseq_pkg::STEP_W + emseq_pkg::NOW_W;
  localparam int RW      = RPW - 8;
  localparam int LW      = emseq_pkg::DIST_TICKS_W + 1;
  localparam int THW     = emseq_pkg::THR_W;

  localparam logic signed [DW-1:0] HALF_S = DW'(ENCODER_COUNTS / 2);
  localparam logic signed [DW-1:0] ENC_S  = DW'(ENCODER_COUNTS);
  localparam logic signed [PW-1:0] S48_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] S48_MIN = {1'b1, {(PW-1){1'b0}}};

  function automatic logic signed [PW-1:0] sat48(input logic signed [SW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > $signed({1'b0, S48_MAX})) begin
      r = S48_MAX;
    end else if (v < $signed({1'b1, S48_MIN})) begin
      r = S48_MIN;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // Start path.
  logic [MW-1:0]                       mag;
  logic                                tiny;
  logic [DPW-1:0]                      dist_prod;
  // Update path.
  logic [emseq_pkg::NOW_W-1:0]         elapsed;
  logic                                timed_out;
  logic [emseq_pkg::NOW_W-1:0]         dt;
  logic [emseq_pkg::NOW_W-1:0]         dt_eff;
  logic [RPW-1:0]                      ramp_prod;
  logic signed [SW-1:0]                ramp;
  logic signed [SW-1:0]                target_sum;
  logic signed [PW-1:0]                target_sat;
  logic signed [DW-1:0]                delta_raw;
  logic signed [DW-1:0]                delta;
  logic signed [SW-1:0]                travel_sum;
  logic signed [PW-1:0]                travel_sat;
  logic signed [SW-1:0]                travel_ext;
  logic signed [SW-1:0]                along;
  logic signed [LW-1:0]                lim_raw;
  logic signed [LW-1:0]                lim_neg;
  logic signed [LW-1:0]                lim;
  logic                                arrived;
  emseq_pkg::mode_t                    mode_nxt;

  assign mag  = item.distance_mm_q8[MW-1] ? MW'(-item.distance_mm_q8)
                                          : MW'(item.distance_mm_q8);
  assign tiny = (mag <= MW'(2));
  assign dist_prod = DPW'(mag) * DPW'(cfg.ticks_per_mm_q8);

  assign elapsed   = item.now_ms - cur.start_time;
  assign timed_out = (elapsed > cfg.timeout_ms);
  assign dt        = item.now_ms - cur.prev_time;
  assign dt_eff    = (dt == '0) ? emseq_pkg::NOW_W'(1) : dt;
  assign ramp_prod = RPW'(cfg.step_per_ms_q8) * RPW'(dt_eff);
  assign ramp      = $signed({{(SW-RW){1'b0}}, ramp_prod[RPW-1:8]});

  assign target_sum = cur.dir_neg ? (SW'(cur.target) - ramp) : (SW'(cur.target) + ramp);
  assign target_sat = sat48(target_sum);

  // Encoder delta, unwrapped across the single-turn boundary.
  assign delta_raw = $signed(DW'(item.encoder_angle)) - $signed(DW'(cur.prev_angle));
  always_comb begin
    if (delta_raw > HALF_S) begin
      delta = delta_raw - ENC_S;
    end else if (delta_raw < -HALF_S) begin
      delta = delta_raw + ENC_S;
    end else begin
      delta = delta_raw;
    end
  end

  assign travel_sum = SW'(cur.travel) + SW'(delta);
  assign travel_sat = sat48(travel_sum);
  assign travel_ext = SW'(travel_sat);
  assign along      = cur.dir_neg ? -travel_ext : travel_ext;

  // Arrival limit in whole ticks, rounded toward zero.
  assign lim_raw = $signed({1'b0, cur.dist_ticks_q8})
                 - $signed({{(LW-THW-8){1'b0}}, cfg.arrive_threshold, 8'b0});
  assign lim_neg = -lim_raw;
  assign lim     = lim_raw[LW-1] ? -(lim_neg >>> 8) : (lim_raw >>> 8);
  assign arrived = (along >= SW'(lim));

  // Mode transitions.
  always_comb begin
    mode_nxt = cur.mode;
    unique case (item.command)
      emseq_pkg::CMD_UPDATE: begin
        if (cur.mode == emseq_pkg::MODE_RUNNING) begin
          if (timed_out) begin
            mode_nxt = emseq_pkg::MODE_TIMEOUT;
          end else if (arrived) begin
            mode_nxt = emseq_pkg::MODE_IDLE;
          end
        end
      end
      emseq_pkg::CMD_START: begin
        if (cur.mode == emseq_pkg::MODE_IDLE && !tiny) begin
          mode_nxt = emseq_pkg::MODE_RUNNING;
        end
      end
      emseq_pkg::CMD_ABORT: begin
        mode_nxt = emseq_pkg::MODE_IDLE;
      end
      default: begin
        mode_nxt = cur.mode;
      end
    endcase
  end

  // Datapath updates.
  always_comb begin
    nxt = cur;
    unique case (item.command)
      emseq_pkg::CMD_UPDATE: begin
        if (cur.mode == emseq_pkg::MODE_RUNNING && !timed_out) begin
          nxt.prev_time  = item.now_ms;
          nxt.target     = target_sat;
          nxt.prev_angle = item.encoder_angle;
          nxt.travel     = travel_sat;
        end
      end
      emseq_pkg::CMD_START: begin
        if (cur.mode == emseq_pkg::MODE_IDLE && !tiny) begin
          nxt.dir_neg       = item.distance_mm_q8[MW-1];
          nxt.dist_ticks_q8 = emseq_pkg::DIST_TICKS_W'(dist_prod[DPW-1:8]);
          nxt.target        = PW'(item.encoder_angle);
          nxt.travel        = '0;
          nxt.prev_angle    = item.encoder_angle;
          nxt.start_time    = item.now_ms;
          nxt.prev_time     = item.now_ms;
        end
      end
      emseq_pkg::CMD_ABORT: begin
        nxt.dir_neg       = 1'b0;
        nxt.dist_ticks_q8 = '0;
        nxt.target        = '0;
        nxt.travel        = '0;
        nxt.prev_angle    = '0;
        nxt.start_time    = '0;
        nxt.prev_time     = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
    nxt.mode = mode_nxt;
  end

endmodule

@@ rtl/encoder_move_sequencer_top.sv @@
// Top level of the encoder move sequencer: handshakes, registers and state.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall  | command, now_ms, encoder_angle, distance
//  out_    | output    | out_valid / out_stall| move_state, target_position
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One word is accepted every cycle while in_stall is low and held in the input register;
// its result goes to the state register behind the out_ ports. The longest path, input
// register to result register, is the 20 x 32 bit ramp multiply and the saturating
// target add. Reset is synchronous on rst_n; it clears the state and handshake flags and
// restores the register defaults, with no clearing pass.
// While out_stall holds a result, one more word waits and in_stall stays high until then.
module encoder_move_sequencer_top #(
  parameter int ENCODER_COUNTS = emseq_pkg::ENCODER_COUNTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [emseq_pkg::CMD_W-1:0]             in_command,
  input  logic [emseq_pkg::NOW_W-1:0]             in_now_ms,
  input  logic [emseq_pkg::ANGLE_W-1:0]           in_encoder_angle,
  input  logic signed [emseq_pkg::DIST_MM_W-1:0]  in_distance_mm_q8,

  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [emseq_pkg::MODE_W-1:0]            out_move_state,
  output logic signed [emseq_pkg::POS_W-1:0]      out_target_position,

  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [emseq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [emseq_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  `include "encoder_move_sequencer_top_assert.svh"

  emseq_pkg::cfg_t       cfg_r;
  emseq_pkg::item_t      in_r;
  logic                  in_vld_r;
  logic                  out_valid_r;
  emseq_pkg::seq_state_t state_r;
  emseq_pkg::seq_state_t state_nxt;
  logic                  fire;
  logic                  in_take;

  // The held word is processed whenever the result slot is empty or being emptied.
  assign fire     = in_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_mm_q8  <= emseq_pkg::TICKS_MM_RST;
      cfg_r.step_per_ms_q8   <= emseq_pkg::STEP_RST;
      cfg_r.arrive_threshold <= emseq_pkg::THR_RST;
      cfg_r.timeout_ms       <= emseq_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (emseq_pkg::cfg_idx_t'(cfg_index))
        emseq_pkg::CFG_TICKS_PER_MM: begin
          cfg_r.ticks_per_mm_q8 <= cfg_wdata[emseq_pkg::TICKS_MM_W-1:0];
        end
        emseq_pkg::CFG_STEP_PER_MS: begin
          cfg_r.step_per_ms_q8 <= cfg_wdata[emseq_pkg::STEP_W-1:0];
        end
        emseq_pkg::CFG_ARRIVE_THR: begin
          cfg_r.arrive_threshold <= cfg_wdata[emseq_pkg::THR_W-1:0];
        end
        emseq_pkg::CFG_TIMEOUT: begin
          cfg_r.timeout_ms <= cfg_wdata[emseq_pkg::TIMEOUT_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Input register: the payload carries no reset, only its valid flag does.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.command        <= emseq_pkg::cmd_t'(in_command);
      in_r.now_ms         <= in_now_ms;
      in_r.encoder_angle  <= in_encoder_angle;
      in_r.distance_mm_q8 <= in_distance_mm_q8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  emseq_step #(
    .ENCODER_COUNTS(ENCODER_COUNTS)
  ) u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (in_r),
    .nxt  (state_nxt)
  );

  // The sequencer state doubles as the result register: it only moves when a
  // word is processed, which cannot happen while a result is being held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= emseq_pkg::MODE_IDLE;
      state_r.dir_neg       <= 1'b0;
      state_r.dist_ticks_q8 <= '0;
      state_r.target        <= '0;
      state_r.travel        <= '0;
      state_r.prev_angle    <= '0;
      state_r.start_time    <= '0;
      state_r.prev_time     <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_move_state      = state_r.mode;
  assign out_target_position = state_r.target;

  `EMSEQ_ASSERT_NXT(a_abort_clears, fire && in_r.command == emseq_pkg::CMD_ABORT,
    state_r.mode == emseq_pkg::MODE_IDLE && state_r.target == '0,
    "abort did not return the sequencer to idle with a cleared target")
  `EMSEQ_ASSERT_NXT(a_timeout_sticky,
    state_r.mode == emseq_pkg::MODE_TIMEOUT && !(fire && in_r.command == emseq_pkg::CMD_ABORT),
    state_r.mode == emseq_pkg::MODE_TIMEOUT,
    "timeout state left without an abort")
  `EMSEQ_ASSERT_NXT(a_state_holds, !fire,
    $stable(state_r),
    "sequencer state changed without a processed word")
  `EMSEQ_ASSERT_NXT(a_result_follows, fire,
    out_valid_r,
    "processed word produced no result")

endmodule

@@ tb/encoder_move_sequencer_top_tb.sv @@
// Self-checking testbench for the encoder move sequencer, with its own predictor of the block.
module encoder_move_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 has no meaning; the block only reports its state for it.
  localparam logic [emseq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ENC_COUNTS = emseq_pkg::ENCODER_COUNTS_DEF;
  localparam longint POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_MIN = -POS_MAX - 1;
  // Extra wait after the block has answered everything, before any register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    emseq_pkg::mode_t                   move_state;
    logic signed [emseq_pkg::POS_W-1:0] target_position;
  } move_result_t;

  // One row of the directed table. When typed is set, the result written in
  // the row is what the block must answer; otherwise the predictor decides.
  typedef struct packed {
    logic [emseq_pkg::CMD_W-1:0]            command;
    logic [emseq_pkg::NOW_W-1:0]            now_ms;
    logic [emseq_pkg::ANGLE_W-1:0]          angle;
    logic signed [emseq_pkg::DIST_MM_W-1:0] distance;
    bit                                     typed;
    move_result_t                           result;
  } stim_row_t;

  localparam move_result_t AT_RESET      = '{emseq_pkg::MODE_IDLE, 48'sd0};
  localparam move_result_t RUN_FROM_TOP  = '{emseq_pkg::MODE_RUNNING, 48'sd8191};
  localparam move_result_t RUN_FROM_ZERO = '{emseq_pkg::MODE_RUNNING, 48'sd0};
  localparam move_result_t RUN_FROM_1000 = '{emseq_pkg::MODE_RUNNING, 48'sd1000};

  logic                                    clk;
  logic                                    rst_n;
  logic                                    in_valid;
  logic                                    in_stall;
  logic [emseq_pkg::CMD_W-1:0]             in_command;
  logic [emseq_pkg::NOW_W-1:0]             in_now_ms;
  logic [emseq_pkg::ANGLE_W-1:0]           in_encoder_angle;
  logic signed [emseq_pkg::DIST_MM_W-1:0]  in_distance_mm_q8;
  logic                                    out_valid;
  logic                                    out_stall;
  logic [emseq_pkg::MODE_W-1:0]            out_move_state;
  logic signed [emseq_pkg::POS_W-1:0]      out_target_position;
  logic                                    cfg_valid;
  logic                                    cfg_ready;
  logic [emseq_pkg::CFG_IDX_W-1:0]         cfg_index;
  logic [emseq_pkg::CFG_DATA_W-1:0]        cfg_wdata;

  encoder_move_sequencer_top #(
    .ENCODER_COUNTS(ENC_COUNTS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_now_ms          (in_now_ms),
    .in_encoder_angle   (in_encoder_angle),
    .in_distance_mm_q8  (in_distance_mm_q8),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_move_state     (out_move_state),
    .out_target_position(out_target_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Directed table: reset behavior, ignored commands, the extremes of every
  // field, wrap of the timestamp and of the encoder, timeout and abort.
  stim_row_t directed_rows [23] = '{
    // Update while idle and the unused command change nothing.
    '{emseq_pkg::CMD_UPDATE, 32'd0,         13'd0,    21'sd0,       1'b1, AT_RESET},
    '{CMD_UNUSED,            32'hFFFF_FFFF, 13'd8191, -21'sd1,      1'b1, AT_RESET},
    // Distances under 0.01 mm never start a move.
    '{emseq_pkg::CMD_START,  32'd10,        13'd8191, 21'sd2,       1'b1, AT_RESET},
    '{emseq_pkg::CMD_START,  32'd10,        13'd8191, -21'sd2,      1'b1, AT_RESET},
    '{emseq_pkg::CMD_ABORT,  32'd0,         13'd0,    21'sd0,       1'b1, AT_RESET},
    // Longest positive move, started just before the timestamp wraps.
    '{emseq_pkg::CMD_START,  32'hFFFF_FFF0, 13'd8191, 21'sd1048575, 1'b1, RUN_FROM_TOP},
    // A second start while running is ignored.
    '{emseq_pkg::CMD_START,  32'hFFFF_FFF1, 13'd5,    21'sd100,     1'b1, RUN_FROM_TOP},
    // Zero elapsed time, then a wrapped timestamp and a wrapped encoder.
    '{emseq_pkg::CMD_UPDATE, 32'hFFFF_FFF0, 13'd8191, 21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_UPDATE, 32'd5,         13'd0,    21'sd0,       1'b0, AT_RESET},
    // Deltas of exactly half a turn are taken as they are.
    '{emseq_pkg::CMD_UPDATE, 32'd5,         13'd4096, 21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_UPDATE, 32'd5,         13'd0,    21'sd0,       1'b0, AT_RESET},
    // One millisecond past the timeout, then start and update are ignored.
    '{emseq_pkg::CMD_UPDATE, 32'h0000_EA51, 13'd0,    21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_START,  32'h0000_EA52, 13'd10,   21'sd500,     1'b0, AT_RESET},
    '{emseq_pkg::CMD_UPDATE, 32'h0000_EA53, 13'd20,   21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_ABORT,  32'h0000_EA54, 13'd20,   21'sd0,       1'b1, AT_RESET},
    // Longest negative move; the update lands exactly on the timeout.
    '{emseq_pkg::CMD_START,  32'd0,         13'd0,    21'sh100000,  1'b1, RUN_FROM_ZERO},
    '{emseq_pkg::CMD_UPDATE, 32'd60000,     13'd8000, 21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_UPDATE, 32'd60000,     13'd0,    21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_ABORT,  32'd60001,     13'd0,    21'sd0,       1'b1, AT_RESET},
    // Shortest moves in both directions arrive on their first update.
    '{emseq_pkg::CMD_START,  32'd100,       13'd1000, 21'sd3,       1'b1, RUN_FROM_1000},
    '{emseq_pkg::CMD_UPDATE, 32'd101,       13'd1000, 21'sd0,       1'b0, AT_RESET},
    '{emseq_pkg::CMD_START,  32'd200,       13'd0,    -21'sd3,      1'b0, AT_RESET},
    '{emseq_pkg::CMD_UPDATE, 32'd200,       13'd8191, 21'sd0,       1'b0, AT_RESET}
  };

  // Predictor copy of the registers.
  logic [emseq_pkg::TICKS_MM_W-1:0] tpm_cfg;
  logic [emseq_pkg::STEP_W-1:0]     step_cfg;
  logic [emseq_pkg::THR_W-1:0]      thr_cfg;
  logic [emseq_pkg::TIMEOUT_W-1:0]  tmo_cfg;

  // Predictor copy of the sequencer state. Positions are kept as 64-bit
  // integers and held inside the signed 48-bit range by clamp_pos.
  emseq_pkg::mode_t              mode_q;
  logic                          dir_neg_q;
  longint                        dist_ticks_q;
  longint                        target_q;
  longint                        travel_q;
  logic [emseq_pkg::ANGLE_W-1:0] prev_angle_q;
  logic [emseq_pkg::NOW_W-1:0]   start_time_q;
  logic [emseq_pkg::NOW_W-1:0]   prev_time_q;

  move_result_t expected_positions[$];
  int           fail_count;
  int           cycle_count;
  int           useful_words;

  // Stimulus context: the simulated millisecond clock, the shaft angle, and
  // the switches for random idling and for very long time steps.
  logic [emseq_pkg::NOW_W-1:0] ms_clock;
  int                          shaft;
  bit                          idling_on;
  bit                          long_haul;

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic void clear_sequencer();
    mode_q       = emseq_pkg::MODE_IDLE;
    dir_neg_q    = 1'b0;
    dist_ticks_q = 0;
    target_q     = 0;
    travel_q     = 0;
    prev_angle_q = '0;
    start_time_q = '0;
    prev_time_q  = '0;
  endfunction

  // Advances the predicted state by one input word and returns the result
  // word the block must send for it.
  function automatic move_result_t sequencer_step(
      logic [emseq_pkg::CMD_W-1:0] cmd, logic [emseq_pkg::NOW_W-1:0] now,
      logic [emseq_pkg::ANGLE_W-1:0] angle, logic signed [emseq_pkg::DIST_MM_W-1:0] dist_mm);
    longint                      mag;
    longint                      ramp;
    longint                      delta;
    longint                      along;
    longint                      limit;
    logic [emseq_pkg::NOW_W-1:0] elapsed;
    logic [emseq_pkg::NOW_W-1:0] dt;
    move_result_t                res;
    if (cmd == emseq_pkg::CMD_ABORT) begin
      clear_sequencer();
    end else if (cmd == emseq_pkg::CMD_START) begin
      mag = (dist_mm < 0) ? -longint'(dist_mm) : longint'(dist_mm);
      if (mode_q == emseq_pkg::MODE_IDLE && mag > 2) begin
        mode_q       = emseq_pkg::MODE_RUNNING;
        dir_neg_q    = (dist_mm < 0);
        dist_ticks_q = (mag * longint'(tpm_cfg)) >>> 8;
        target_q     = longint'(angle);
        travel_q     = 0;
        prev_angle_q = angle;
        start_time_q = now;
        prev_time_q  = now;
      end
    end else if (cmd == emseq_pkg::CMD_UPDATE && mode_q == emseq_pkg::MODE_RUNNING) begin
      elapsed = now - start_time_q;
      if (elapsed > tmo_cfg) begin
        mode_q = emseq_pkg::MODE_TIMEOUT;
      end else begin
        dt          = now - prev_time_q;
        prev_time_q = now;
        if (dt == '0) dt = 1;
        ramp     = (longint'(step_cfg) * longint'(dt)) >>> 8;
        target_q = clamp_pos(dir_neg_q ? target_q - ramp : target_q + ramp);
        // Take the short way around the turn.
        delta        = longint'(angle) - longint'(prev_angle_q);
        prev_angle_q = angle;
        if (delta > ENC_COUNTS / 2) delta -= ENC_COUNTS;
        if (delta < -(ENC_COUNTS / 2)) delta += ENC_COUNTS;
        travel_q = clamp_pos(travel_q + delta);
        along    = dir_neg_q ? -travel_q : travel_q;
        // Arrival limit in whole ticks, truncated toward zero.
        limit = dist_ticks_q - (longint'(thr_cfg) <<< 8);
        limit = (limit >= 0) ? (limit >>> 8) : -((-limit) >>> 8);
        if (along >= limit) mode_q = emseq_pkg::MODE_IDLE;
      end
    end
    res.move_state      = mode_q;
    res.target_position = target_q[emseq_pkg::POS_W-1:0];
    return res;
  endfunction

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side back-pressure: random stall bursts, changed on the falling edge
  // so the block sees a settled value at the rising edge.
  initial begin
    int burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!idling_on) burst = 0;
      else if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 7);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every result word taken by the testbench is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : result_check
    move_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        $error("result word with nothing expected: move_state %0d, target_position %0d",
               out_move_state, out_target_position);
        fail_count++;
      end else begin
        due = expected_positions.pop_front();
        if (out_move_state !== due.move_state) begin
          $error("move_state: expected %0d, got %0d", due.move_state, out_move_state);
          fail_count++;
        end
        if (out_target_position !== due.target_position) begin
          $error("target_position: expected %0d, got %0d",
                 due.target_position, out_target_position);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offers one input word, holds it until the block takes it, and records
  // the result it must produce. A random idle burst may come first.
  task automatic send_word(input logic [emseq_pkg::CMD_W-1:0] cmd,
                           input logic [emseq_pkg::NOW_W-1:0] now,
                           input logic [emseq_pkg::ANGLE_W-1:0] angle,
                           input logic signed [emseq_pkg::DIST_MM_W-1:0] dist_mm,
                           input bit typed, input move_result_t typed_res);
    int           gap;
    move_result_t due;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_now_ms         <= now;
    in_encoder_angle  <= angle;
    in_distance_mm_q8 <= dist_mm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = sequencer_step(cmd, now, angle, dist_mm);
    expected_positions.push_back(typed ? typed_res : due);
  endtask

  // Stops sending and waits until every expected result has come back, then
  // waits out the settle time so the block is quiet before any register write.
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input emseq_pkg::cfg_idx_t idx,
                                input logic [emseq_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      emseq_pkg::CFG_TICKS_PER_MM: tpm_cfg  = value[emseq_pkg::TICKS_MM_W-1:0];
      emseq_pkg::CFG_STEP_PER_MS:  step_cfg = value[emseq_pkg::STEP_W-1:0];
      emseq_pkg::CFG_ARRIVE_THR:   thr_cfg  = value[emseq_pkg::THR_W-1:0];
      emseq_pkg::CFG_TIMEOUT:      tmo_cfg  = value[emseq_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [emseq_pkg::CFG_DATA_W-1:0] tpm,
                               input logic [emseq_pkg::CFG_DATA_W-1:0] stp,
                               input logic [emseq_pkg::CFG_DATA_W-1:0] thr,
                               input logic [emseq_pkg::CFG_DATA_W-1:0] tmo);
    write_register(emseq_pkg::CFG_TICKS_PER_MM, tpm);
    write_register(emseq_pkg::CFG_STEP_PER_MS, stp);
    write_register(emseq_pkg::CFG_ARRIVE_THR, thr);
    write_register(emseq_pkg::CFG_TIMEOUT, tmo);
  endtask

  // One well-formed move: a start from idle, then a run of update ticks that
  // walk the shaft in the move direction, with occasional stray starts,
  // reversals, jumps, timeouts and aborts mixed in.
  task automatic run_move();
    logic signed [emseq_pkg::DIST_MM_W-1:0] dist_mm;
    logic [emseq_pkg::NOW_W-1:0]            dt;
    int                                     dir;
    int                                     steps;
    int                                     pick;
    if (mode_q != emseq_pkg::MODE_IDLE) begin
      send_word(emseq_pkg::CMD_ABORT, ms_clock, emseq_pkg::ANGLE_W'(shaft), '0, 1'b0, '0);
      useful_words++;
    end
    case ($urandom_range(0, 9))
      0: dist_mm = emseq_pkg::DIST_MM_W'($urandom);
      1: dist_mm = $signed(emseq_pkg::DIST_MM_W'($urandom_range(0, 4))) - 21'sd2;
      default: begin
        dist_mm = emseq_pkg::DIST_MM_W'($urandom_range(3, 2500));
        if ($urandom_range(0, 1) == 1) dist_mm = -dist_mm;
      end
    endcase
    send_word(emseq_pkg::CMD_START, ms_clock, emseq_pkg::ANGLE_W'(shaft), dist_mm, 1'b0, '0);
    useful_words++;
    dir   = (dist_mm < 0) ? -1 : 1;
    steps = $urandom_range(1, 60);
    for (int k = 0; k < steps && mode_q != emseq_pkg::MODE_IDLE; k++) begin
      pick = $urandom_range(0, 39);
      if (pick == 0 || (mode_q == emseq_pkg::MODE_TIMEOUT && pick < 16)) begin
        send_word(emseq_pkg::CMD_ABORT, ms_clock, emseq_pkg::ANGLE_W'(shaft),
                  emseq_pkg::DIST_MM_W'($urandom), 1'b0, '0);
      end else if (pick == 1) begin
        send_word(emseq_pkg::CMD_START, ms_clock, emseq_pkg::ANGLE_W'(shaft),
                  emseq_pkg::DIST_MM_W'($urandom), 1'b0, '0);
      end else begin
        dt = $urandom_range(0, 25);
        if (long_haul) dt = $urandom;
        else if (pick == 2 && tmo_cfg < 32'hFFFF_0000) dt = tmo_cfg + $urandom_range(1, 100);
        ms_clock += dt;
        if (pick == 3) shaft = int'($urandom_range(0, ENC_COUNTS - 1));
        else if (pick < 8) shaft -= dir * int'($urandom_range(0, 300));
        else shaft += dir * int'($urandom_range(0, 900));
        shaft = ((shaft % ENC_COUNTS) + ENC_COUNTS) % ENC_COUNTS;
        send_word(emseq_pkg::CMD_UPDATE, ms_clock, emseq_pkg::ANGLE_W'(shaft),
                  emseq_pkg::DIST_MM_W'($urandom), 1'b0, '0);
      end
      useful_words++;
    end
  endtask

  // Mostly moves; about one pick in ten sends a single fully random word instead, and now
  // and then a pause until the block has answered everything.
  task automatic run_phase(input int words);
    int goal;
    goal     = useful_words + words;
    ms_clock = $urandom;
    while (useful_words < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(emseq_pkg::CMD_W'($urandom), $urandom, emseq_pkg::ANGLE_W'($urandom),
                  emseq_pkg::DIST_MM_W'($urandom), 1'b0, '0);
      end else begin
        run_move();
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = emseq_pkg::CMD_UPDATE;
    in_now_ms         = '0;
    in_encoder_angle  = '0;
    in_distance_mm_q8 = '0;
    cfg_valid         = 1'b0;
    cfg_index         = emseq_pkg::CFG_TICKS_PER_MM;
    cfg_wdata         = '0;
    fail_count        = 0;
    useful_words      = 0;
    idling_on         = 1'b1;
    long_haul         = 1'b0;
    ms_clock          = '0;
    shaft             = 0;
    tpm_cfg           = emseq_pkg::TICKS_MM_RST;
    step_cfg          = emseq_pkg::STEP_RST;
    thr_cfg           = emseq_pkg::THR_RST;
    tmo_cfg           = emseq_pkg::TIMEOUT_RST;
    clear_sequencer();

    // Synchronous reset, released on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part, run on the reset register values.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].command, directed_rows[i].now_ms, directed_rows[i].angle,
                directed_rows[i].distance, directed_rows[i].typed, directed_rows[i].result);
    end
    wait_drained();

    // Random moves on the reset settings.
    run_phase(200);
    wait_drained();

    // Every register at zero: instant arrival and instant timeout.
    load_settings('0, '0, '0, '0);
    run_phase(120);
    wait_drained();

    // Every register at its maximum, with huge time steps so that the target
    // runs into its saturation limits.
    long_haul = 1'b1;
    load_settings(32'h00FF_FFFF, 32'h000F_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
    run_phase(150);
    wait_drained();
    long_haul = 1'b0;

    // Random settings in a range where moves arrive or time out often.
    repeat (3) begin
      load_settings($urandom_range(20000, 400000), $urandom_range(0, 400000),
                    $urandom_range(0, 2000), $urandom_range(20, 3000));
      run_phase(220);
      wait_drained();
    end

    // Closing stretch at full rate on both sides.
    idling_on = 1'b0;
    load_settings(emseq_pkg::TICKS_MM_RST, emseq_pkg::STEP_RST, emseq_pkg::THR_RST,
                  emseq_pkg::TIMEOUT_RST);
    run_phase(250);
    wait_drained();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
